@@ rtl/keypad_passcode_lock_core_assert.svh @@
// Assertion macros for the keypad passcode lock.
`ifndef KEYPAD_PASSCODE_LOCK_CORE_ASSERT_SVH
`define KEYPAD_PASSCODE_LOCK_CORE_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define KPL_ASSERT_SAME(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define KPL_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/kpl_pkg.sv @@
`timescale 1ns / 1ps

package kpl_pkg;

	// Request kinds
	localparam logic REQ_KEY  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam int CFG_IDX_W  = 3;

	// Key codes that matter to the send logic
	localparam logic [7:0] KEY_STAR     = 8'h2A;
	localparam logic [7:0] KEY_HASH     = 8'h23;
	localparam logic [7:0] KEY_A        = 8'h41;
	localparam logic [7:0] KEY_B        = 8'h42;
	localparam logic [7:0] KEY_C        = 8'h43;
	localparam logic [7:0] KEY_D        = 8'h44;
	localparam logic [7:0] KEY_QUESTION = 8'h3F;

	// Register reset values
	localparam logic [7:0]  PASS_FIRST_RST  = 8'h31;
	localparam logic [7:0]  PASS_SECOND_RST = 8'h35;
	localparam logic [7:0]  PASS_THIRD_RST  = 8'h33;
	localparam logic [15:0] TIMEOUT_RST     = 16'd32768;
	localparam logic [6:0]  LED_TARGET_RST  = 7'h13;
	localparam logic [6:0]  LCD_TARGET_RST  = 7'h46;

	typedef enum logic [1:0] {
		STAGE_WAIT,
		STAGE_ONE,
		STAGE_TWO,
		STAGE_OPEN
	} lock_stage_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PASS_FIRST,
		REG_PASS_SECOND,
		REG_PASS_THIRD,
		REG_ENTRY_TIMEOUT,
		REG_STAR_WINDOW,
		REG_LED_TARGET,
		REG_LCD_TARGET
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  pass_first;
		logic [7:0]  pass_second;
		logic [7:0]  pass_third;
		logic [15:0] entry_timeout;
		logic [15:0] star_window;
		logic [6:0]  led_target;
		logic [6:0]  lcd_target;
	} cfg_t;

	typedef struct packed {
		logic [6:0] target_addr;
		logic [7:0] data_byte;
		logic       last_of_run;
	} result_t;

	// Results of one request: n is 0, 1 or 2
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		lock_stage_t stage;
	} eng_stat_t;

	// Decode a row/column pattern; bit 8 flags a valid key
	function automatic logic [8:0] key_decode(input logic [7:0] pattern);
		logic [8:0] res;
		unique case (pattern)
			8'h11: res = {1'b1, 8'h31};
			8'h12: res = {1'b1, 8'h32};
			8'h14: res = {1'b1, 8'h33};
			8'h18: res = {1'b1, KEY_A};
			8'h21: res = {1'b1, 8'h34};
			8'h22: res = {1'b1, 8'h35};
			8'h24: res = {1'b1, 8'h36};
			8'h28: res = {1'b1, KEY_B};
			8'h41: res = {1'b1, 8'h37};
			8'h42: res = {1'b1, 8'h38};
			8'h44: res = {1'b1, 8'h39};
			8'h48: res = {1'b1, KEY_C};
			8'h81: res = {1'b1, KEY_STAR};
			8'h82: res = {1'b1, 8'h30};
			8'h84: res = {1'b1, KEY_HASH};
			8'h88: res = {1'b1, KEY_D};
			default: res = 9'h000;
		endcase
		return res;
	endfunction

	function automatic logic is_led_key(input logic [7:0] code);
		return (code == KEY_STAR) || (code == KEY_A) || (code == KEY_B) ||
			(code == KEY_C) || (code == KEY_D) || (code == KEY_HASH);
	endfunction

endpackage

@@ rtl/kpl_req_if.sv @@
`timescale 1ns / 1ps

interface kpl_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] key_pattern;

	modport source (output valid, req_type, key_pattern, input ready);
	modport sink (input valid, req_type, key_pattern, output ready);
endinterface

@@ rtl/kpl_res_if.sv @@
`timescale 1ns / 1ps

interface kpl_res_if;
	logic       valid;
	logic       ready;
	logic [6:0] target_addr;
	logic [7:0] data_byte;
	logic       last_of_run;

	modport source (output valid, target_addr, data_byte, last_of_run, input ready);
	modport sink (input valid, target_addr, data_byte, last_of_run, output ready);
endinterface

@@ rtl/kpl_cfg_if.sv @@
`timescale 1ns / 1ps

interface kpl_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/kpl_cfg_regs.sv @@
`timescale 1ns / 1ps

module kpl_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	kpl_cfg_if.sink       cfg,
	output kpl_pkg::cfg_t regs
);
	import kpl_pkg::*;

	cfg_t regs_q;

	// Always take a write request
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Load the addressed register; drop writes past the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pass_first    <= PASS_FIRST_RST;
			regs_q.pass_second   <= PASS_SECOND_RST;
			regs_q.pass_third    <= PASS_THIRD_RST;
			regs_q.entry_timeout <= TIMEOUT_RST;
			regs_q.star_window   <= TIMEOUT_RST;
			regs_q.led_target    <= LED_TARGET_RST;
			regs_q.lcd_target    <= LCD_TARGET_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_PASS_FIRST:    regs_q.pass_first    <= cfg.data[7:0];
				REG_PASS_SECOND:   regs_q.pass_second   <= cfg.data[7:0];
				REG_PASS_THIRD:    regs_q.pass_third    <= cfg.data[7:0];
				REG_ENTRY_TIMEOUT: regs_q.entry_timeout <= cfg.data;
				REG_STAR_WINDOW:   regs_q.star_window   <= cfg.data;
				REG_LED_TARGET:    regs_q.led_target    <= cfg.data[6:0];
				REG_LCD_TARGET:    regs_q.lcd_target    <= cfg.data[6:0];
				default: ;
			endcase
		end
	end
endmodule

@@ rtl/kpl_engine.sv @@
`timescale 1ns / 1ps

module kpl_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic               req_type,
	input  logic [7:0]         key_pattern,
	input  kpl_pkg::cfg_t      cfg,
	output kpl_pkg::push_t     push,
	output kpl_pkg::eng_stat_t stat
);
	import kpl_pkg::*;

	lock_stage_t stage_q, stage_d;
	logic [7:0]  key_q, key_d;
	logic [15:0] entry_ticks_q, entry_ticks_d;
	logic        entry_run_q, entry_run_d;
	logic        star_armed_q, star_armed_d;
	logic [15:0] star_ticks_q, star_ticks_d;

	logic [8:0]  dec;
	logic [7:0]  key_now;
	logic [7:0]  led_byte;
	logic [15:0] entry_inc;
	logic [15:0] star_inc;

	assign stat.stage = stage_q;

	// Hold state; clear control on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q       <= STAGE_WAIT;
			key_q         <= 8'h00;
			entry_ticks_q <= 16'h0000;
			entry_run_q   <= 1'b0;
			star_armed_q  <= 1'b0;
			star_ticks_q  <= 16'h0000;
		end else begin
			stage_q       <= stage_d;
			key_q         <= key_d;
			entry_ticks_q <= entry_ticks_d;
			entry_run_q   <= entry_run_d;
			star_armed_q  <= star_armed_d;
			star_ticks_q  <= star_ticks_d;
		end
	end

	assign dec       = key_decode(key_pattern);
	assign key_now   = dec[8] ? dec[7:0] : key_q;
	assign entry_inc = entry_ticks_q + 16'd1;
	assign star_inc  = star_ticks_q + 16'd1;

	// Work out next state and the results of the accepted request
	always_comb begin
		stage_d       = stage_q;
		key_d         = key_q;
		entry_ticks_d = entry_ticks_q;
		entry_run_d   = entry_run_q;
		star_armed_d  = star_armed_q;
		star_ticks_d  = star_ticks_q;
		led_byte      = key_now;
		push          = '0;

		if (fire) begin
			if (req_type == REQ_TICK) begin
				// Advance the entry timer; expire a locked entry
				if (entry_run_q) begin
					entry_ticks_d = entry_inc;
					if (entry_inc >= cfg.entry_timeout) begin
						entry_run_d   = 1'b0;
						entry_ticks_d = 16'h0000;
						if (stage_q != STAGE_OPEN) begin
							stage_d = STAGE_WAIT;
						end
					end
				end
				// Advance the star window; disarm at its end
				if (star_armed_q) begin
					star_ticks_d = star_inc;
					if (star_inc >= cfg.star_window) begin
						star_armed_d = 1'b0;
						star_ticks_d = 16'h0000;
					end
				end
			end else begin
				key_d = key_now;
				unique case (stage_q)
					STAGE_WAIT: begin
						entry_run_d   = 1'b1;
						entry_ticks_d = 16'h0000;
						stage_d = (key_now == cfg.pass_first) ? STAGE_ONE : STAGE_WAIT;
					end
					STAGE_ONE: begin
						stage_d = (key_now == cfg.pass_second) ? STAGE_TWO : STAGE_WAIT;
					end
					STAGE_TWO: begin
						stage_d = (key_now == cfg.pass_third) ? STAGE_OPEN : STAGE_WAIT;
					end
					STAGE_OPEN: begin
						// Arm on a first star, send '?' on a second one
						if (key_now == KEY_STAR) begin
							if (!star_armed_q) begin
								star_armed_d = 1'b1;
								star_ticks_d = 16'h0000;
							end else begin
								star_armed_d = 1'b0;
								led_byte     = KEY_QUESTION;
							end
						end
						if (is_led_key(key_now)) begin
							push.n  = 2'd2;
							push.r0 = '{target_addr: cfg.led_target, data_byte: led_byte,
								last_of_run: 1'b0};
							push.r1 = '{target_addr: cfg.lcd_target, data_byte: key_now,
								last_of_run: 1'b1};
						end else begin
							push.n  = 2'd1;
							push.r0 = '{target_addr: cfg.lcd_target, data_byte: key_now,
								last_of_run: 1'b1};
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule

@@ rtl/kpl_res_fifo.sv @@
`timescale 1ns / 1ps

module kpl_res_fifo #(
	parameter int Depth = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kpl_pkg::push_t             push,
	kpl_res_if.source                  res,
	output logic [$clog2(Depth+1)-1:0] count
);
	import kpl_pkg::*;

	localparam int PW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);

	result_t        mem [Depth];
	logic [PW-1:0]  wr_q, rd_q;
	logic [PW-1:0]  wr1, wr2;
	logic [CW-1:0]  count_q;
	logic           pop;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr1   = ptr_next(wr_q);
	assign wr2   = ptr_next(wr1);
	assign pop   = res.valid && res.ready;
	assign count = count_q;

	assign res.valid       = (count_q != '0);
	assign res.target_addr = mem[rd_q].target_addr;
	assign res.data_byte   = mem[rd_q].data_byte;
	assign res.last_of_run = mem[rd_q].last_of_run;

	// Store up to two results per request
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wr1] <= push.r1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.n == 2'd1) begin
				wr_q <= wr1;
			end else if (push.n == 2'd2) begin
				wr_q <= wr2;
			end
			if (pop) begin
				rd_q <= ptr_next(rd_q);
			end
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end
endmodule

@@ rtl/keypad_passcode_lock_core.sv @@
// Keypad passcode lock core.
// A result is written into the result queue as its request is accepted.
// Throughput: one request per cycle while the result queue has two free slots;
// results leave one per cycle while the receiver is ready, so a two-result key leaves as two transfers.
// Reset (arst_n low, asynchronous): locked, timers stopped, registers to defaults.
`timescale 1ns / 1ps

module keypad_passcode_lock_core #(
	parameter int FifoDepth = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	kpl_req_if.sink   req,
	kpl_res_if.source res,
	kpl_cfg_if.sink   cfg
);
	import kpl_pkg::*;

	`include "keypad_passcode_lock_core_assert.svh"

	localparam int CW = $clog2(FifoDepth + 1);

	cfg_t          regs;
	push_t         push;
	eng_stat_t     stat;
	logic [CW-1:0] count;
	logic          fire;

	// Take a request only when two result slots are free
	assign req.ready = (count <= CW'(FifoDepth - 2));
	assign fire      = req.valid && req.ready;

	kpl_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	kpl_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.req_type    (req.req_type),
		.key_pattern (req.key_pattern),
		.cfg         (regs),
		.push        (push),
		.stat        (stat)
	);

	kpl_res_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res    (res),
		.count  (count)
	);

	// Checks
	`KPL_ASSERT_SAME(a_room, clk, arst_n, fire, count <= CW'(FifoDepth - 2), "queue lacks room")
	`KPL_ASSERT_SAME(a_locked_quiet, clk, arst_n, push.n != 2'd0, stat.stage == STAGE_OPEN, "result while locked")
	`KPL_ASSERT_SAME(a_pair_last, clk, arst_n, push.n == 2'd2, !push.r0.last_of_run && push.r1.last_of_run, "bad last flag on pair")
	`KPL_ASSERT_NEXT(a_open_stays, clk, arst_n, stat.stage == STAGE_OPEN, stat.stage == STAGE_OPEN, "lock closed again")
endmodule

@@ tb/tb_keypad_passcode_lock_core.sv @@
`timescale 1ns / 1ps

module tb_keypad_passcode_lock_core;
	import kpl_pkg::*;

	localparam int HOLD_OFF_CYCLES = 80;
	localparam int HOLD_AFTER_BYTES = 120;
	localparam int PHASE_REQUESTS = 220;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT = 300000;
	localparam int MAX_REPORTS = 30;

	// Keypad legend, row-major: row line 0..3 by column line 0..3
	localparam logic [8*16-1:0] KEYPAD_LEGEND = "123A456B789C*0#D";

	typedef enum logic [1:0] {
		ROW_KEY,
		ROW_TICK,
		ROW_REG
	} row_kind_t;

	// Optional hand-written expectation carried alongside a request
	typedef struct packed {
		logic  typed;
		push_t due;
	} offer_t;

	typedef struct packed {
		row_kind_t   kind;
		cfg_reg_t    reg_sel;
		logic [15:0] value;
		offer_t      note;
	} stim_row_t;

	localparam offer_t NO_NOTE = '0;
	localparam offer_t NO_BYTES = '{typed: 1'b1, due: '0};

	logic clk;
	logic arst_n;

	kpl_req_if req_ch ();
	kpl_res_if res_ch ();
	kpl_cfg_if cfg_ch ();

	keypad_passcode_lock_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the lock
	cfg_t        shadow;
	lock_stage_t stage;
	logic [7:0]  held_key;
	logic [15:0] entry_cnt;
	logic [15:0] star_cnt;
	logic        entry_on;
	logic        star_on;

	result_t   bytes_due[$];
	offer_t    offers[$];
	stim_row_t script[$];

	int errors;
	int requests_offered;
	int requests_taken;
	int bytes_checked;
	int question_marks;
	int cycle_count;
	bit calm;
	bit held_off;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [8:0] keypad_code(input logic [7:0] pattern);
		int row;
		int col;
		row = 0;
		col = 0;
		if (!$onehot(pattern[7:4]) || !$onehot(pattern[3:0]))
			return 9'h000;
		for (int i = 0; i < 4; i++) begin
			if (pattern[4+i])
				row = i;
			if (pattern[i])
				col = i;
		end
		return {1'b1, KEYPAD_LEGEND[8*(15-(row*4+col)) +: 8]};
	endfunction

	function automatic offer_t lcd_byte(input logic [6:0] addr, input logic [7:0] data);
		offer_t note;
		note = NO_BYTES;
		note.due.n = 2'd1;
		note.due.r0 = '{addr, data, 1'b1};
		return note;
	endfunction

	function automatic offer_t led_lcd_bytes(input logic [6:0] led_addr,
			input logic [7:0] led_data, input logic [6:0] lcd_addr,
			input logic [7:0] lcd_data);
		offer_t note;
		note = NO_BYTES;
		note.due.n = 2'd2;
		note.due.r0 = '{led_addr, led_data, 1'b0};
		note.due.r1 = '{lcd_addr, lcd_data, 1'b1};
		return note;
	endfunction

	// Advance the shadow lock by one request and return the bytes it sends
	function automatic void advance_lock(input logic kind, input logic [7:0] pattern,
			output push_t out);
		logic [8:0] dec;
		logic [7:0] led_data;
		out = '0;
		if (kind == REQ_TICK) begin
			if (entry_on) begin
				entry_cnt = entry_cnt + 16'd1;
				if (entry_cnt >= shadow.entry_timeout) begin
					entry_on = 1'b0;
					entry_cnt = '0;
					if (stage != STAGE_OPEN)
						stage = STAGE_WAIT;
				end
			end
			if (star_on) begin
				star_cnt = star_cnt + 16'd1;
				if (star_cnt >= shadow.star_window) begin
					star_on = 1'b0;
					star_cnt = '0;
				end
			end
			return;
		end
		// an unknown pattern repeats the last key
		dec = keypad_code(pattern);
		if (dec[8])
			held_key = dec[7:0];
		case (stage)
			STAGE_WAIT: begin
				entry_on = 1'b1;
				entry_cnt = '0;
				stage = (held_key == shadow.pass_first) ? STAGE_ONE : STAGE_WAIT;
			end
			STAGE_ONE: begin
				stage = (held_key == shadow.pass_second) ? STAGE_TWO : STAGE_WAIT;
			end
			STAGE_TWO: begin
				stage = (held_key == shadow.pass_third) ? STAGE_OPEN : STAGE_WAIT;
			end
			default: begin
				led_data = held_key;
				if (held_key == KEY_STAR) begin
					if (!star_on) begin
						star_on = 1'b1;
						star_cnt = '0;
					end else begin
						star_on = 1'b0;
						led_data = KEY_QUESTION;
					end
				end
				if (held_key inside {KEY_STAR, KEY_A, KEY_B, KEY_C, KEY_D, KEY_HASH}) begin
					out.n = 2'd2;
					out.r0 = '{shadow.led_target, led_data, 1'b0};
					out.r1 = '{shadow.lcd_target, held_key, 1'b1};
				end else begin
					out.n = 2'd1;
					out.r0 = '{shadow.lcd_target, held_key, 1'b1};
				end
			end
		endcase
	endfunction

	task automatic report_bad(input string what, input int got, input int want);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("ERROR %0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	// Track accepted requests, register writes and returned bytes
	always @(posedge clk) begin
		push_t   due;
		offer_t  note;
		result_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				note = offers.pop_front();
				advance_lock(req_ch.req_type, req_ch.key_pattern, due);
				if (note.typed)
					due = note.due;
				if (due.n > 2'd0)
					bytes_due.push_back(due.r0);
				if (due.n > 2'd1)
					bytes_due.push_back(due.r1);
				requests_taken++;
			end
			if (res_ch.valid && res_ch.ready) begin
				bytes_checked++;
				if (res_ch.data_byte == KEY_QUESTION)
					question_marks++;
				if (bytes_due.size() == 0) begin
					report_bad("byte with nothing due", res_ch.data_byte, 0);
				end else begin
					want = bytes_due.pop_front();
					if (res_ch.target_addr != want.target_addr)
						report_bad("target_addr", res_ch.target_addr, want.target_addr);
					if (res_ch.data_byte != want.data_byte)
						report_bad("data_byte", res_ch.data_byte, want.data_byte);
					if (res_ch.last_of_run != want.last_of_run)
						report_bad("last_of_run", res_ch.last_of_run, want.last_of_run);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_reg_t'(cfg_ch.index))
					REG_PASS_FIRST:    shadow.pass_first = cfg_ch.data[7:0];
					REG_PASS_SECOND:   shadow.pass_second = cfg_ch.data[7:0];
					REG_PASS_THIRD:    shadow.pass_third = cfg_ch.data[7:0];
					REG_ENTRY_TIMEOUT: shadow.entry_timeout = cfg_ch.data;
					REG_STAR_WINDOW:   shadow.star_window = cfg_ch.data;
					REG_LED_TARGET:    shadow.led_target = cfg_ch.data[6:0];
					REG_LCD_TARGET:    shadow.lcd_target = cfg_ch.data[6:0];
					default: ;
				endcase
			end
		end
	end

	// Offer one request, with a random gap first unless running calm
	task automatic offer_request(input logic kind, input logic [7:0] pattern,
			input offer_t note);
		while (!calm && $urandom_range(99) < 23) begin
			req_ch.valid <= 1'b0;
			cfg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		// close any register write still being offered
		cfg_ch.valid <= 1'b0;
		offers.push_back(note);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.key_pattern <= pattern;
		requests_offered++;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Write one register; the caller lowers valid with its next request
	task automatic write_reg(input cfg_reg_t sel, input logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= sel;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// Drain every byte due, then allow for a request that sends nothing
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (bytes_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stalls, one long hold-off once traffic is flowing
	initial begin
		held_off = 1'b0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && bytes_checked >= HOLD_AFTER_BYTES) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				held_off = 1'b1;
			end
			res_ch.ready <= calm || ($urandom_range(99) >= 23);
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run exceeded %0d cycles with %0d bytes still due", CYCLE_LIMIT,
			bytes_due.size());
		$display("keypad_passcode_lock_core: mismatch");
		$finish;
	end

	// Directed requests, then random phases under several register settings
	initial begin
		bit          quiet;
		int          pick;
		int          start;
		int          gap;
		logic [15:0] win;
		errors = 0;
		requests_offered = 0;
		requests_taken = 0;
		bytes_checked = 0;
		question_marks = 0;
		calm = 1'b0;
		quiet = 1'b1;
		shadow = '{PASS_FIRST_RST, PASS_SECOND_RST, PASS_THIRD_RST, TIMEOUT_RST,
			TIMEOUT_RST, LED_TARGET_RST, LCD_TARGET_RST};
		stage = STAGE_WAIT;
		held_key = '0;
		entry_cnt = '0;
		star_cnt = '0;
		entry_on = 1'b0;
		star_on = 1'b0;

		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_TICK;
		req_ch.key_pattern <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_PASS_FIRST;
		cfg_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// key code is 0 until a valid key: make that the first digit
		script.push_back('{ROW_REG, REG_PASS_FIRST, 16'h0000, NO_NOTE});
		script.push_back('{ROW_TICK, REG_PASS_FIRST, 16'h00A5, NO_BYTES});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0000, NO_BYTES});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0022, NO_NOTE});
		// unknown pattern repeats '5' against third digit '3'
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h00FF, NO_NOTE});
		// zero timeout expires on the first tick; passcode A D 0
		script.push_back('{ROW_REG, REG_ENTRY_TIMEOUT, 16'h0000, NO_NOTE});
		script.push_back('{ROW_REG, REG_PASS_FIRST, 16'h0041, NO_NOTE});
		script.push_back('{ROW_REG, REG_PASS_SECOND, 16'h0044, NO_NOTE});
		script.push_back('{ROW_REG, REG_PASS_THIRD, 16'h0030, NO_NOTE});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0018, NO_NOTE});
		script.push_back('{ROW_TICK, REG_PASS_FIRST, 16'h0000, NO_NOTE});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0088, NO_NOTE});
		// two-tick timeout: expire at stage two, then mismatch at stage one
		script.push_back('{ROW_REG, REG_ENTRY_TIMEOUT, 16'h0002, NO_NOTE});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0018, NO_NOTE});
		script.push_back('{ROW_TICK, REG_PASS_FIRST, 16'h005A, NO_NOTE});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0088, NO_NOTE});
		script.push_back('{ROW_TICK, REG_PASS_FIRST, 16'h00FF, NO_NOTE});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0082, NO_NOTE});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0018, NO_NOTE});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0018, NO_NOTE});
		// full code inside the timeout opens the lock
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0018, NO_NOTE});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0088, NO_NOTE});
		script.push_back('{ROW_TICK, REG_PASS_FIRST, 16'h0000, NO_NOTE});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0082, NO_BYTES});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0011,
			lcd_byte(LCD_TARGET_RST, 8'h31)});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0081,
			led_lcd_bytes(LED_TARGET_RST, KEY_STAR, LCD_TARGET_RST, KEY_STAR)});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0081,
			led_lcd_bytes(LED_TARGET_RST, KEY_QUESTION, LCD_TARGET_RST, KEY_STAR)});
		// unknown pattern repeats the star and arms again
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0000, NO_NOTE});
		script.push_back('{ROW_REG, REG_STAR_WINDOW, 16'h0000, NO_NOTE});
		script.push_back('{ROW_REG, REG_LED_TARGET, 16'h0000, NO_NOTE});
		script.push_back('{ROW_REG, REG_LCD_TARGET, 16'h007F, NO_NOTE});
		script.push_back('{ROW_TICK, REG_PASS_FIRST, 16'h0000, NO_NOTE});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0081,
			led_lcd_bytes(7'h00, KEY_STAR, 7'h7F, KEY_STAR)});
		script.push_back('{ROW_KEY, REG_PASS_FIRST, 16'h0084, NO_NOTE});

		foreach (script[i]) begin
			case (script[i].kind)
				ROW_REG: begin
					if (!quiet)
						settle();
					quiet = 1'b1;
					write_reg(script[i].reg_sel, script[i].value);
				end
				ROW_TICK: begin
					offer_request(REQ_TICK, script[i].value[7:0], script[i].note);
					quiet = 1'b0;
				end
				default: begin
					offer_request(REQ_KEY, script[i].value[7:0], script[i].note);
					quiet = 1'b0;
				end
			endcase
		end

		// Random phases; the lock stays open from here on
		for (int p = 0; p < 4; p++) begin
			settle();
			calm = (p == 2);
			case (p)
				0: win = 16'd1;
				1: win = 16'hFFFF;
				default: win = 16'($urandom_range(2, 6));
			endcase
			write_reg(REG_PASS_FIRST, (p == 1) ? 16'h00FF : 16'($urandom_range(255)));
			write_reg(REG_PASS_SECOND, (p == 1) ? 16'h00FF : 16'($urandom_range(255)));
			write_reg(REG_PASS_THIRD, (p == 1) ? 16'h00FF : 16'($urandom_range(255)));
			write_reg(REG_ENTRY_TIMEOUT,
				(p == 1) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
			write_reg(REG_STAR_WINDOW, win);
			write_reg(REG_LED_TARGET, (p == 0) ? 16'd127 : 16'($urandom_range(127)));
			write_reg(REG_LCD_TARGET, (p == 0) ? 16'd0 : 16'($urandom_range(127)));
			start = requests_offered;
			while (requests_offered - start < PHASE_REQUESTS) begin
				pick = $urandom_range(99);
				if (pick < 40) begin
					// star, ticks around the window, star again
					gap = $urandom_range(0, (win > 16'd8) ? 8 : int'(win) + 1);
					offer_request(REQ_KEY, 8'h81, NO_NOTE);
					repeat (gap)
						offer_request(REQ_TICK, 8'($urandom_range(255)), NO_NOTE);
					offer_request(REQ_KEY, 8'h81, NO_NOTE);
				end else if (pick < 65) begin
					offer_request(REQ_KEY, {4'(1 << $urandom_range(3)),
						4'(1 << $urandom_range(3))}, NO_NOTE);
				end else if (pick < 80) begin
					repeat ($urandom_range(1, 4))
						offer_request(REQ_TICK, 8'($urandom_range(255)), NO_NOTE);
				end else begin
					// raw pattern, mostly unknown
					offer_request(REQ_KEY, 8'($urandom_range(255)), NO_NOTE);
				end
			end
		end

		settle();
		$display("Covered %0d requests over five register settings, %0d bytes checked",
			requests_taken, bytes_checked);
		$display("Double-star bytes seen: %0d, receiver hold-off done: %0d",
			question_marks, held_off);
		if (errors == 0 && bytes_due.size() == 0)
			$display("keypad_passcode_lock_core: match");
		else
			$display("keypad_passcode_lock_core: mismatch");
		$finish;
	end

endmodule
